### rtl/pacs_pkg.sv
`timescale 1ns / 1ps

package pacs_pkg;

   // slot store geometry
   localparam int SLOT_COUNT = 8;
   localparam int CODE_W     = 8;
   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

   // result field widths
   localparam int ENTRY_W    = 4;
   localparam int RSP_DATA_W = 8;

   // request kinds
   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   // slot memory access from the sequencer
   typedef struct packed {
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [CODE_W-1:0] wr_data;
   } mem_req_type;

   // one finished result
   typedef struct packed {
      logic               changed;
      logic [ENTRY_W-1:0] entry_count;
      logic               list_full;
   } result_type;

endpackage

### rtl/packed_alarm_code_set.sv
`timescale 1ns / 1ps

// Packed set of distinct nonzero alarm codes held in SLOT_COUNT slots.
// Request channel (req_*): req_tdata carries the alarm code, req_tuser the
// request kind (0 add, 1 remove). A word is taken when req_tvalid and
// req_tready are both high. Code zero is ignored.
// Result channel (rsp_*): one word per request with the changed flag, the
// entry count after the request and the full flag.
// Timing: the slot memory is read one slot per cycle until the code is
// found or the occupied slots are exhausted; a remove then moves each later
// entry down, one slot per cycle. Scan and shift together touch each of the
// n occupied slots at most once; code zero or an empty list skips both. The
// next request word can be taken once the result word has moved from the
// done state into the output register.
// One request is worked on at a time; req_tready is high only while idle.
// Reset empties the list at once (the entry count is cleared; slot memory
// beyond the count is never read), and drops any pending result word.
// When the receiver stalls, the result word is held in the output register;
// a later result waits in the done state until that word is taken.
module packed_alarm_code_set
   import pacs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CODE_W-1:0]     req_tdata,   // [7:0] alarm_code
   input  logic                  req_tuser,   // [0] func
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [0] changed, [4:1] entry_count,
                                              // [5] list_full, [7:6] zero
);

   mem_req_type       mem_req;
   logic [CODE_W-1:0] mem_rd_data;
   logic              res_valid;
   logic              res_ready;
   result_type        res;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   pacs_ram #(
      .WIDTH (CODE_W),
      .DEPTH (SLOT_COUNT)
   ) u_slots (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

   pacs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_func    (req_tuser),
      .req_code    (req_tdata),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   // output register takes a result when empty or being drained
   assign res_ready = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (res_ready) begin
         rsp_tvalid_in = res_valid;
         if (res_valid) begin
            rsp_tdata_in = RSP_DATA_W'({res.list_full, res.entry_count, res.changed});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

### rtl/pacs_ram.sv
`timescale 1ns / 1ps

module pacs_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/pacs_ctrl.sv
`timescale 1ns / 1ps

module pacs_ctrl
   import pacs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request side
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_func,
   input  logic [CODE_W-1:0] req_code,
   // slot memory
   output mem_req_type       mem_req,
   input  logic [CODE_W-1:0] mem_rd_data,
   // result side
   output logic              res_valid,
   input  logic              res_ready,
   output result_type        res
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              func_ff, func_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              changed_ff, changed_in;

   logic [CNT_W-1:0]  idx_ext;
   logic [CNT_W-1:0]  last_idx;
   logic              at_last;
   logic              shift_last;
   logic              accept;

   assign idx_ext    = CNT_W'(idx_ff);
   assign last_idx   = count_ff - CNT_W'(1);
   assign at_last    = (idx_ext == last_idx);
   assign shift_last = ((idx_ext + CNT_W'(2)) == count_ff);
   assign accept     = req_valid && req_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

   // result fields from the updated count
   assign res.changed     = changed_ff;
   assign res.entry_count = ENTRY_W'(count_ff);
   assign res.list_full   = (count_ff == CNT_W'(SLOT_COUNT));

   // sequencer: scan slots one read per cycle, then append for an add or shift down for a remove
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      func_in    = func_ff;
      code_in    = code_ff;
      changed_in = changed_ff;
      mem_req    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in    = req_func;
               code_in    = req_code;
               changed_in = 1'b0;
               idx_in     = '0;
               if (req_code == '0) begin
                  state_in = ST_DONE;
               end else if (count_ff == '0) begin
                  // empty list: an add goes straight to slot zero
                  if (req_func == FUNC_ADD) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = '0;
                     mem_req.wr_data = req_code;
                     count_in        = CNT_W'(1);
                     changed_in      = 1'b1;
                  end
                  state_in = ST_DONE;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = '0;
                  state_in        = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (mem_rd_data == code_ff) begin
               if (func_ff == FUNC_ADD) begin
                  state_in = ST_DONE;
               end else if (at_last) begin
                  // last entry removed, nothing to move
                  count_in   = last_idx;
                  changed_in = 1'b1;
                  state_in   = ST_DONE;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = IDX_W'(idx_ext + CNT_W'(1));
                  state_in        = ST_SHIFT;
               end
            end else if (at_last) begin
               // code absent
               if (func_ff == FUNC_ADD && count_ff != CNT_W'(SLOT_COUNT)) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = IDX_W'(count_ff);
                  mem_req.wr_data = code_ff;
                  count_in        = count_ff + CNT_W'(1);
                  changed_in      = 1'b1;
               end
               state_in = ST_DONE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = IDX_W'(idx_ext + CNT_W'(1));
               idx_in          = IDX_W'(idx_ext + CNT_W'(1));
            end
         end

         ST_SHIFT: begin
            // read data holds the entry above idx; move it down
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff;
            mem_req.wr_data = mem_rd_data;
            if (shift_last) begin
               count_in   = last_idx;
               changed_in = 1'b1;
               state_in   = ST_DONE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = IDX_W'(idx_ext + CNT_W'(2));
               idx_in          = IDX_W'(idx_ext + CNT_W'(1));
            end
         end

         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // request payload and scan position
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      func_ff    <= func_in;
      code_ff    <= code_in;
      changed_ff <= changed_in;
   end

endmodule
